### hdl/acbd_pkg.sv
// Shared types, constants and byte functions for the AES-128 CBC block decryptor.
`default_nettype none
package acbd_pkg;

  localparam int unsigned BlkBits   = 128;
  localparam int unsigned HalfBits  = 64;
  localparam int unsigned NumRounds = 10;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KEY_HIGH = 2'd0;
  localparam cfg_idx_t CFG_KEY_LOW  = 2'd1;
  localparam cfg_idx_t CFG_IV_HIGH  = 2'd2;
  localparam cfg_idx_t CFG_IV_LOW   = 2'd3;

  localparam logic [HalfBits-1:0] IvReset = 64'h4949_4949_4949_4949;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYS,
    ST_ROUND,
    ST_DONE
  } ctl_state_t;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic load;
    logic key_step;
    logic rnd_step;
    logic last;
  } rnd_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] x2, x4, x8;
    x2 = xtime(a);
    x4 = xtime(x2);
    x8 = xtime(x4);
    gmul = (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^ (b[2] ? x4 : 8'h00) ^
           (b[3] ? x8 : 8'h00);
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage
`default_nettype wire

### hdl/acbd_keysched.sv
// Key schedule: forward expansion to the last round key, then backward one word a cycle.
`default_nettype none
module acbd_keysched (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire acbd_pkg::rnd_ctl_t      ctl,
  input  wire logic [127:0]            key,
  output logic [127:0]                 rkey
);
  import acbd_pkg::*;

  // Key held as four words w0..w3 in [127:0]; one word of the schedule a cycle.
  // fwd: forward word steps reach round 10, then each four bwd word steps give the prior round.
  logic [127:0] k_r, k_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic [7:0]   rcon_prev;
  logic [1:0]   pos_r, pos_nxt;
  logic [31:0]  t_word;
  logic [31:0]  new_w;

  function automatic logic [31:0] sub_rot(input logic [31:0] w);
    sub_rot = {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  // ctl.load: reset to key; ctl.key_step forward; ctl.rnd_step backward one word.
  always_comb begin
    k_nxt     = k_r;
    rcon_nxt  = rcon_r;
    pos_nxt   = pos_r;
    t_word    = 32'h0;
    new_w     = 32'h0;
    rcon_prev = {1'b0, rcon_r[7:1]} ^ (rcon_r[0] ? 8'h8d : 8'h00);
    if (ctl.load) begin
      k_nxt    = key;
      rcon_nxt = 8'h01;
      pos_nxt  = 2'd0;
    end else if (ctl.key_step) begin
      // Rotate words: new word = w0 ^ f(w3 or previous new)
      t_word = (pos_r == 2'd0) ? (sub_rot(k_r[31:0]) ^ {rcon_r, 24'h0}) : k_r[31:0];
      new_w  = k_r[127:96] ^ t_word;
      k_nxt  = {k_r[95:0], new_w};
      pos_nxt = pos_r + 2'd1;
      if (pos_r == 2'd3) rcon_nxt = xtime(rcon_r);
    end else if (ctl.rnd_step) begin
      // Backward: window [a,b,c,d] -> recover word before a: a_prev = d_cur ^ f(c_cur)
      // Process in reverse: pos counts down; rcon steps back before its use.
      t_word  = (pos_r == 2'd1) ? (sub_rot(k_r[63:32]) ^ {rcon_prev, 24'h0}) : k_r[63:32];
      new_w   = k_r[31:0] ^ t_word;
      k_nxt   = {new_w, k_r[127:32]};
      pos_nxt = pos_r - 2'd1;
      if (pos_r == 2'd1) rcon_nxt = rcon_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      rcon_r <= 8'h01;
    end else begin
      pos_r  <= pos_nxt;
      rcon_r <= rcon_nxt;
    end
    k_r <= k_nxt;
  end

  assign rkey = k_r;

endmodule
`default_nettype wire

### hdl/acbd_round.sv
// Inverse round datapath: block load, initial key add and one inverse cipher round per enabled cycle.
`default_nettype none
module acbd_round (
  input  wire logic                clk,
  input  wire acbd_pkg::rnd_ctl_t  ctl,
  input  wire logic [127:0]        din,
  input  wire logic [127:0]        rkey,
  output logic [127:0]             state
);
  import acbd_pkg::*;

  logic [127:0] s_r, s_nxt;
  logic [7:0]   sb [16];
  logic [7:0]   ak [16];
  logic [7:0]   mx [16];

  // byte i sits at s_r[127-8i -: 8]; byte index r + 4c.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4 * ((c + r) % 4)] = INV_SBOX[s_r[127 - 8 * (r + 4 * c) -: 8]];
      end
    end
    for (int i = 0; i < 16; i++) begin
      ak[i] = sb[i] ^ rkey[127 - 8 * i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mx[4 * c + r] = gmul(ak[4 * c + r], 4'd14) ^ gmul(ak[4 * c + (r + 1) % 4], 4'd11) ^
                        gmul(ak[4 * c + (r + 2) % 4], 4'd13) ^
                        gmul(ak[4 * c + (r + 3) % 4], 4'd9);
      end
    end
    s_nxt = s_r;
    if (ctl.load) begin
      s_nxt = din;
    end else if (ctl.key_step) begin
      s_nxt = s_r ^ rkey;
    end else if (ctl.rnd_step) begin
      for (int i = 0; i < 16; i++) begin
        s_nxt[127 - 8 * i -: 8] = ctl.last ? ak[i] : mx[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  assign state = s_r;

endmodule
`default_nettype wire

### hdl/aes128_cbc_block_decrypt_top.sv
// Top level of the AES-128 CBC block decryptor.
//
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_stall   | cipher_high, cipher_low, first_block
// out_    | output    | out_valid / out_stall | plain_high, plain_low
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An item runs from accept to accept through the load, forward key expansion (one
// schedule word a cycle), the initial key add, 40 backward schedule steps with a
// round applied on every fourth, the final round and DONE, which waits while the
// output register is full. out_valid is registered, set as DONE loads out_r.
// Reset is synchronous, rst_n low; key and IV registers reset to their defaults.
// The result sits in an output register; the next item is taken while it waits.
`default_nettype none
module aes128_cbc_block_decrypt_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_cipher_high,
  input  wire logic [63:0] in_cipher_low,
  input  wire logic        in_first_block,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_plain_high,
  output logic [63:0]      out_plain_low,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import acbd_pkg::*;

  ctl_state_t   st_r, st_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [127:0] prev_r, cur_r;
  logic         first_r;
  logic         ov_r, ov_nxt;
  logic [127:0] out_r;
  rnd_ctl_t     ctl;
  rnd_ctl_t     rctl;
  logic         rnd_apply;
  logic [127:0] rkey, state;
  logic         in_acc, out_acc, cfg_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != ST_IDLE);

  acbd_keysched u_ks (.clk(clk), .rst_n(rst_n), .ctl(ctl), .key({key_hi_r, key_lo_r}),
                      .rkey(rkey));
  acbd_round u_rnd (.clk(clk), .ctl(rctl), .din({in_cipher_high, in_cipher_low}),
                    .rkey(rkey), .state(state));

  // Sequence: KEYS = 40 forward steps; then ROUND: add last key, 40 backward
  // steps, with the final round once the schedule is back at round 0.
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    ctl      = '0;
    ov_nxt   = ov_r;
    if (out_acc) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.load = 1'b1;
          cnt_nxt  = 6'd0;
          st_nxt   = ST_KEYS;
        end
      end
      ST_KEYS: begin
        ctl.key_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd39) begin
          cnt_nxt = 6'd0;
          st_nxt  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // cnt 0: state ^= round key 10 while the schedule holds.
        if (cnt_r == 6'd0) begin
          cnt_nxt = 6'd1;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd41) begin
            ctl.last = 1'b1;
            st_nxt = ST_DONE;
          end else begin
            ctl.rnd_step = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!ov_r || out_acc) begin
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // A full round key is in the schedule window at cnt 5, 9, ... 41.
  assign rnd_apply = (st_r == ST_ROUND) && (cnt_r[1:0] == 2'd1) && (cnt_r != 6'd1);
  always_comb begin
    rctl = '0;
    rctl.load     = ctl.load;
    rctl.key_step = (st_r == ST_ROUND) && (cnt_r == 6'd0);
    rctl.rnd_step = rnd_apply;
    rctl.last     = ctl.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= 6'd0;
      ov_r     <= 1'b0;
      key_hi_r <= '0;
      key_lo_r <= '0;
      iv_hi_r  <= IvReset;
      iv_lo_r  <= IvReset;
      prev_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_KEY_HIGH: key_hi_r <= cfg_data;
          CFG_KEY_LOW:  key_lo_r <= cfg_data;
          CFG_IV_HIGH:  iv_hi_r  <= cfg_data;
          CFG_IV_LOW:   iv_lo_r  <= cfg_data;
          default: ;
        endcase
      end
      if (st_r == ST_DONE && st_nxt == ST_IDLE) prev_r <= cur_r;
    end
    if (in_acc) begin
      cur_r   <= {in_cipher_high, in_cipher_low};
      first_r <= in_first_block;
    end
    if (st_r == ST_DONE && st_nxt == ST_IDLE) begin
      out_r <= state ^ (first_r ? {iv_hi_r, iv_lo_r} : prev_r);
    end
  end

  assign out_valid      = ov_r;
  assign out_plain_high = out_r[127:64];
  assign out_plain_low  = out_r[63:0];

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_acc) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_done_from_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r == ST_DONE) |-> $past(st_r == ST_ROUND)) else $error("bad done entry");

endmodule
`default_nettype wire
